[hw/rtl/boxf_pkg.sv]
`default_nettype none
package boxf_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned REG_W      = 11;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned COLSUM_W   = 10;
  localparam int unsigned SUM_W      = 12;
  localparam int unsigned PROD_W     = 24;
  localparam int unsigned DIV9_SHIFT = 15;
  localparam int unsigned CHAIN_LEN  = 2;

  localparam logic [PROD_W-1:0] DIV9_MUL    = PROD_W'(3641);
  localparam logic [REG_W-1:0]  SIDE_MIN    = REG_W'(3);
  localparam logic [REG_W-1:0]  HEIGHT_MAX  = REG_W'(1024);
  localparam logic [REG_W-1:0]  WIDTH_RESET = REG_W'(100);
  localparam logic [REG_W-1:0]  HEIGHT_RST  = REG_W'(100);

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] up2;
    logic [PIX_W-1:0] up1;
    logic [PIX_W-1:0] cur;
  } column_t;

  typedef struct packed {
    logic shift;
    logic top;
    logic bot;
  } cell_ctrl_t;

  function automatic logic [COLSUM_W-1:0] col_sum(column_t c, logic top, logic bot);
    logic [COLSUM_W-1:0] s;
    s = COLSUM_W'(c.up1);
    if (top) s = s + COLSUM_W'(c.up2);
    if (bot) s = s + COLSUM_W'(c.cur);
    return s;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/boxf_ram.sv]
`default_nettype none
module boxf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/boxf_cell.sv]
`default_nettype none
module boxf_cell (
  input  wire logic                 clk_i,
  input  wire boxf_pkg::cell_ctrl_t ctrl_i,
  input  wire boxf_pkg::column_t    col_i,
  output boxf_pkg::column_t         col_o,
  output logic [boxf_pkg::COLSUM_W-1:0] sum_o
);
  import boxf_pkg::*;

  column_t col_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;
  assign sum_o = col_sum(col_q, ctrl_i.top, ctrl_i.bot);

endmodule
`default_nettype wire

[hw/rtl/box_filter_3x3_zero_pad.sv]
// 3x3 mean filter with zero padding for one grayscale frame in raster order.
// Configure image_width (byte address 0) and image_height (byte address 4)
// over the APB port while the block is idle; any write restarts the frame.
// Input stream: tdata carries the pixel, tuser the command (0 pixel,
// 1 flush). After width*height pixels send width+1 flush transactions to
// drain the frame; the next transaction then starts a new frame.
// Output stream: tdata carries the filtered pixel, tlast marks the final
// pixel of the frame. Output pixel k belongs to input transaction k+width+1
// and passes the s1 and s2 stage registers into the output register.
// Throughput is one transaction per cycle while the receiver keeps up: the
// line store is one dual-port RAM (one read, one write per cycle) and the
// window is a two-cell column shift chain. When the receiver stalls with the
// output register full, s_axis_tready drops and the whole pipeline holds.
// Reset sets both dimensions to 100 and clears the frame position; the line
// store is not cleared, since stale entries are always masked out.
`default_nettype none
module box_filter_3x3_zero_pad #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [boxf_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [boxf_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [boxf_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [boxf_pkg::PIX_W-1:0]      s_axis_tdata,  // [7:0] pixel_in
  input  wire logic                            s_axis_tuser,  // [0] command
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic      [boxf_pkg::PIX_W-1:0]      m_axis_tdata,  // [7:0] pixel_out
  output logic                                 m_axis_tlast
);
  import boxf_pkg::*;

  localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  typedef struct packed {
    logic             shift;
    logic             emit;
    logic             line_start;
    logic             top;
    logic             bot;
    logic             use_old;
    logic             last;
    logic [PIX_W-1:0] pix;
    logic [COL_W-1:0] addr;
  } s1_t;

  logic [REG_W-1:0] width_q, height_q;
  logic [REG_W-1:0] w_use, h_use;
  logic [REG_W:0]   h_p1;
  logic             cfg_wr;

  logic [COL_W-1:0] ic_q, ic_d, ic;
  logic [REG_W-1:0] ir_q, ir_d, ir;
  logic             restart, in_fire, adv, s1_fire;

  s1_t              s1_d, s1_q;
  logic             s1_valid_q;
  logic             ls_emit, mid_emit;

  logic [2*PIX_W-1:0] rd_data;
  column_t            new_col;
  cell_ctrl_t         cell_ctrl;
  column_t            chain_col [CHAIN_LEN];
  logic [COLSUM_W-1:0] cell_sum [CHAIN_LEN];
  logic [COLSUM_W-1:0] new_sum;
  logic [SUM_W-1:0]    s2_sum_d, s2_sum_q;
  logic                s2_valid_q, s2_last_q;
  logic [PROD_W-1:0]   prod;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_WIDTH:  width_q  <= pwdata[REG_W-1:0];
        REG_HEIGHT: height_q <= pwdata[REG_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WIDTH:  prdata = APB_DATA_W'(width_q);
      REG_HEIGHT: prdata = APB_DATA_W'(height_q);
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    w_use = width_q;
    if (w_use < SIDE_MIN) w_use = SIDE_MIN;
    if (32'(w_use) > 32'(MAX_WIDTH)) w_use = REG_W'(MAX_WIDTH);
    h_use = height_q;
    if (h_use < SIDE_MIN) h_use = SIDE_MIN;
    if (h_use > HEIGHT_MAX) h_use = HEIGHT_MAX;
  end

  assign h_p1 = {1'b0, h_use} + (REG_W+1)'(1);

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign in_fire       = s_axis_tvalid && adv;
  assign s1_fire       = s1_valid_q && adv;

  always_comb begin
    restart = (32'(ic_q) >= 32'(w_use)) || ({1'b0, ir_q} > h_p1);
    ic      = restart ? '0 : ic_q;
    ir      = restart ? '0 : ir_q;

    ls_emit  = (ic == '0) && (ir >= REG_W'(2));
    mid_emit = (ic != '0) && (ir >= REG_W'(1));

    s1_d.shift      = (ir <= h_use);
    s1_d.emit       = ls_emit || mid_emit;
    s1_d.line_start = ls_emit;
    s1_d.top        = ls_emit ? (ir >= REG_W'(3)) : (ir >= REG_W'(2));
    s1_d.bot        = ls_emit ? (ir <= h_use) : (ir < h_use);
    s1_d.use_old    = (32'(ic) >= 32'd2);
    s1_d.last       = ({1'b0, ir} == h_p1);
    s1_d.pix        = (s_axis_tuser == CMD_FLUSH || ir >= h_use) ? '0 : s_axis_tdata;
    s1_d.addr       = ic;

    if ({1'b0, ir} == h_p1) begin
      ic_d = '0;
      ir_d = '0;
    end else if (32'(ic) + 32'd1 >= 32'(w_use)) begin
      ic_d = '0;
      ir_d = ir + REG_W'(1);
    end else begin
      ic_d = ic + COL_W'(1);
      ir_d = ir;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ic_q <= '0;
      ir_q <= '0;
    end else if (cfg_wr) begin
      ic_q <= '0;
      ir_q <= '0;
    end else if (in_fire) begin
      ic_q <= ic_d;
      ir_q <= ir_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      s1_valid_q    <= in_fire;
      s2_valid_q    <= s1_valid_q && s1_q.emit;
      m_axis_tvalid <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
    if (adv) begin
      s2_sum_q     <= s2_sum_d;
      s2_last_q    <= s1_q.last;
      m_axis_tdata <= prod[DIV9_SHIFT +: PIX_W];
      m_axis_tlast <= s2_last_q;
    end
  end

  boxf_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .wr_en_i   (s1_fire && s1_q.shift),
    .wr_addr_i (s1_q.addr),
    .wr_data_i ({rd_data[PIX_W-1:0], s1_q.pix}),
    .rd_en_i   (in_fire),
    .rd_addr_i (ic),
    .rd_data_o (rd_data)
  );

  assign new_col.up2 = rd_data[2*PIX_W-1:PIX_W];
  assign new_col.up1 = rd_data[PIX_W-1:0];
  assign new_col.cur = s1_q.pix;

  assign cell_ctrl.shift = s1_fire && s1_q.shift;
  assign cell_ctrl.top   = s1_q.top;
  assign cell_ctrl.bot   = s1_q.bot;

  for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_chain
    if (i == 0) begin : g_tail
      boxf_cell u_cell (
        .clk_i  (clk_i),
        .ctrl_i (cell_ctrl),
        .col_i  (chain_col[i+1]),
        .col_o  (chain_col[i]),
        .sum_o  (cell_sum[i])
      );
    end else if (i == CHAIN_LEN - 1) begin : g_head
      boxf_cell u_cell (
        .clk_i  (clk_i),
        .ctrl_i (cell_ctrl),
        .col_i  (new_col),
        .col_o  (chain_col[i]),
        .sum_o  (cell_sum[i])
      );
    end else begin : g_mid
      boxf_cell u_cell (
        .clk_i  (clk_i),
        .ctrl_i (cell_ctrl),
        .col_i  (chain_col[i+1]),
        .col_o  (chain_col[i]),
        .sum_o  (cell_sum[i])
      );
    end
  end

  assign new_sum = col_sum(new_col, s1_q.top, s1_q.bot);

  always_comb begin
    if (s1_q.line_start) begin
      s2_sum_d = SUM_W'(cell_sum[0]) + SUM_W'(cell_sum[1]);
    end else begin
      s2_sum_d = (s1_q.use_old ? SUM_W'(cell_sum[0]) : '0)
               + SUM_W'(cell_sum[1]) + SUM_W'(new_sum);
    end
  end

  assign prod = PROD_W'(s2_sum_q) * DIV9_MUL;

endmodule
`default_nettype wire

[verif/boxf_mean_checker.sv]
`timescale 1ns / 1ps
module boxf_mean_checker #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [boxf_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [boxf_pkg::APB_DATA_W-1:0] pwdata,
  input  logic [boxf_pkg::APB_DATA_W-1:0] prdata,
  input  logic                            pready,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [boxf_pkg::PIX_W-1:0]      s_axis_tdata,  // [7:0] pixel_in
  input  logic                            s_axis_tuser,  // [0] command
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [boxf_pkg::PIX_W-1:0]      m_axis_tdata,  // [7:0] pixel_out
  input  logic                            m_axis_tlast,
  output int                              pending_o,
  output int                              fail_count_o,
  output int                              checked_o
);
  import boxf_pkg::*;

  localparam int unsigned NEIGHBORHOOD = 9;
  localparam int unsigned OUT_INDEX_MASK = 20'hFFFFF;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_end;
  } mean_pixel_t;

  mean_pixel_t expected_means[$];

  logic [REG_W-1:0] width_reg;
  logic [REG_W-1:0] height_reg;
  logic [PIX_W-1:0] line_prev[MAX_WIDTH];
  logic [PIX_W-1:0] line_prev2[MAX_WIDTH];
  logic [PIX_W-1:0] window_px[9];
  int unsigned      next_col;
  int unsigned      next_row;
  int unsigned      out_index;

  function automatic int unsigned side_in_use(logic [REG_W-1:0] v, int unsigned hi);
    if (v < SIDE_MIN) return 32'(SIDE_MIN);
    if (32'(v) > hi) return hi;
    return 32'(v);
  endfunction

  function automatic int unsigned window_total(bit top, bit bot, int unsigned lo);
    int unsigned s;
    s = 0;
    for (int unsigned c = lo; c < 3; c++) begin
      if (top) s += 32'(window_px[c]);
      s += 32'(window_px[3 + c]);
      if (bot) s += 32'(window_px[6 + c]);
    end
    return s;
  endfunction

  function automatic void queue_mean(int unsigned sum, int unsigned w, int unsigned h);
    mean_pixel_t e;
    e.pixel     = PIX_W'(sum / NEIGHBORHOOD);
    e.frame_end = (out_index == w * h - 1);
    expected_means.push_back(e);
    out_index = (out_index + 1) & OUT_INDEX_MASK;
  endfunction

  task automatic advance_window(logic cmd, logic [PIX_W-1:0] data);
    int unsigned w, h, r, c;
    logic [PIX_W-1:0] pix, up2, up1;
    w = side_in_use(width_reg, MAX_WIDTH);
    h = side_in_use(height_reg, 32'(HEIGHT_MAX));
    r = next_row;
    c = next_col;
    pix = (cmd == CMD_FLUSH) ? '0 : data;
    if (c >= w || r > h + 1) begin
      next_col = 0;
      next_row = 0;
      out_index = 0;
      r = 0;
      c = 0;
    end
    if (r >= h) pix = '0;
    // finish the last pixel of the line two rows up
    if (c == 0 && r >= 2) queue_mean(window_total(r - 2 >= 1, r - 1 < h, 1), w, h);
    if (r <= h && c < MAX_WIDTH) begin
      up2 = line_prev2[c];
      up1 = line_prev[c];
      line_prev2[c] = up1;
      line_prev[c]  = pix;
      for (int k = 0; k < 3; k++) begin
        window_px[3*k]     = window_px[3*k + 1];
        window_px[3*k + 1] = window_px[3*k + 2];
      end
      window_px[2] = up2;
      window_px[5] = up1;
      window_px[8] = pix;
    end
    if (c >= 1 && r >= 1) queue_mean(window_total(r - 1 >= 1, r < h, (c >= 2) ? 0 : 1), w, h);
    if (r == h + 1) begin
      next_col = 0;
      next_row = 0;
      out_index = 0;
    end else begin
      c++;
      if (c >= w) begin
        c = 0;
        r++;
      end
      next_col = c;
      next_row = r;
    end
  endtask

  always @(posedge clk_i) begin
    mean_pixel_t exp_px;
    logic [REG_W-1:0] reg_val;
    if (!rst_ni) begin
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RST;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        line_prev[i]  = '0;
        line_prev2[i] = '0;
      end
      for (int i = 0; i < 9; i++) window_px[i] = '0;
      next_col  = 0;
      next_row  = 0;
      out_index = 0;
      expected_means.delete();
    end else begin
      if (psel && penable && pready) begin
        reg_val = (paddr[2] == REG_WIDTH) ? width_reg : height_reg;
        if (pwrite) begin
          if (paddr[2] == REG_WIDTH) width_reg = pwdata[REG_W-1:0];
          else height_reg = pwdata[REG_W-1:0];
          next_col  = 0;
          next_row  = 0;
          out_index = 0;
        end else if (prdata !== APB_DATA_W'(reg_val)) begin
          $display("%0t: register read at 0x%0h: expected %0d actual %0d",
                   $time, paddr, reg_val, prdata);
          fail_count_o++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) advance_window(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_means.size() == 0) begin
          $display("%0t: unexpected filtered pixel: expected none actual %0d last %0b",
                   $time, m_axis_tdata, m_axis_tlast);
          fail_count_o++;
        end else begin
          exp_px = expected_means.pop_front();
          if (m_axis_tdata !== exp_px.pixel) begin
            $display("%0t: pixel_out: expected %0d actual %0d",
                     $time, exp_px.pixel, m_axis_tdata);
            fail_count_o++;
          end
          if (m_axis_tlast !== exp_px.frame_end) begin
            $display("%0t: frame_last: expected %0b actual %0b",
                     $time, exp_px.frame_end, m_axis_tlast);
            fail_count_o++;
          end
          checked_o++;
        end
      end
    end
    pending_o = expected_means.size();
  end

endmodule

[verif/box_filter_3x3_zero_pad_test.sv]
`timescale 1ns / 1ps
module box_filter_3x3_zero_pad_test;
  import boxf_pkg::*;

  localparam int unsigned MAX_WIDTH     = 1024;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned RANDOM_ITEMS  = 600;
  localparam int unsigned PARTIAL_ITEMS = 30;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [PIX_W-1:0]      s_axis_tdata;  // [7:0] pixel_in
  logic                  s_axis_tuser;  // [0] command
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [PIX_W-1:0]      m_axis_tdata;  // [7:0] pixel_out
  logic                  m_axis_tlast;

  int pending_means;
  int mean_errors;
  int means_checked;

  bit               hold_req;
  bit               hold_active;
  int unsigned      burst_left;
  int unsigned      items_sent;
  int unsigned      frames_sent;
  int unsigned      geometries;
  logic [REG_W-1:0] cur_w;
  logic [REG_W-1:0] cur_h;

  box_filter_3x3_zero_pad #(
    .MAX_WIDTH(MAX_WIDTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  boxf_mean_checker #(
    .MAX_WIDTH(MAX_WIDTH)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .pending_o    (pending_means),
    .fail_count_o (mean_errors),
    .checked_o    (means_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(64'd20_000_000);
    $display("box_filter_3x3_zero_pad regression: fail");
    $finish;
  end

  initial begin
    int unsigned seg, pct;
    m_axis_tready = 1'b0;
    forever begin
      if (hold_req) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_active = 1'b0;
        hold_req = 1'b0;
      end
      seg = $urandom_range(20, 120);
      case ($urandom_range(0, 3))
        0: pct = 0;
        1: pct = 20;
        2: pct = 50;
        default: pct = 80;
      endcase
      repeat (seg) begin
        @(negedge clk_i);
        m_axis_tready <= ($urandom_range(0, 99) >= pct);
      end
    end
  end

  function automatic int unsigned used_side(logic [REG_W-1:0] v, int unsigned hi);
    if (v < SIDE_MIN) return 32'(SIDE_MIN);
    if (32'(v) > hi) return hi;
    return 32'(v);
  endfunction

  task automatic apb_access(bit wr, logic index, logic [REG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {index, 2'b00};
    pwdata  <= {(APB_DATA_W - REG_W)'($urandom), value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_geometry(int unsigned w, int unsigned h);
    apb_access(1'b1, REG_WIDTH, REG_W'(w));
    apb_access(1'b1, REG_HEIGHT, REG_W'(h));
    apb_access(1'b0, REG_WIDTH, '0);
    apb_access(1'b0, REG_HEIGHT, '0);
    cur_w = REG_W'(w);
    cur_h = REG_W'(h);
    geometries++;
  endtask

  task automatic offer(logic cmd, logic [PIX_W-1:0] pix);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= PIX_W'($urandom);
        s_axis_tuser  <= 1'($urandom);
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_means != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic send_frame(bit noisy);
    int unsigned w, h, n_pix, n_all;
    logic cmd;
    logic [PIX_W-1:0] pix;
    w = used_side(cur_w, MAX_WIDTH);
    h = used_side(cur_h, 32'(HEIGHT_MAX));
    n_pix = w * h;
    n_all = n_pix + w + 1;
    // cut short or overrun the drain now and then
    if (noisy && $urandom_range(0, 99) < 8) n_all = n_all + $urandom_range(0, 6) - 3;
    for (int unsigned k = 0; k < n_all; k++) begin
      cmd = (k < n_pix) ? CMD_PIXEL : CMD_FLUSH;
      if (noisy && $urandom_range(0, 99) < 4) cmd = ~cmd;
      case ($urandom_range(0, 9))
        0: pix = '0;
        1: pix = '1;
        default: pix = PIX_W'($urandom);
      endcase
      offer(cmd, pix);
    end
    frames_sent++;
  endtask

  initial begin
    logic cmd;
    logic [PIX_W-1:0] pix;
    int unsigned random_start;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_PIXEL;
    hold_req      = 1'b0;
    hold_active   = 1'b0;
    burst_left    = 0;
    items_sent    = 0;
    frames_sent   = 0;
    geometries    = 0;
    cur_w         = WIDTH_RESET;
    cur_h         = HEIGHT_RST;
    rst_ni        = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    apb_access(1'b0, REG_WIDTH, '0);
    apb_access(1'b0, REG_HEIGHT, '0);
    for (int k = 0; k < 150; k++) offer(CMD_PIXEL, PIX_W'($urandom));
    settle();

    set_geometry(3, 3);
    for (int k = 0; k < 13; k++) begin
      cmd = (k < 9) ? CMD_PIXEL : CMD_FLUSH;
      pix = (k == 6) ? '0 : '1;
      // flush inside the pixel phase reads as zero
      if (k == 4) cmd = CMD_FLUSH;
      // pixel inside the drain acts as a flush
      if (k == 10) begin
        cmd = CMD_PIXEL;
        pix = 8'hA5;
      end
      offer(cmd, pix);
    end
    settle();

    set_geometry(4, 3);
    for (int k = 0; k < 6; k++) offer(CMD_PIXEL, '1);
    settle();
    set_geometry(4, 3);
    send_frame(1'b0);
    settle();

    // hold the receiver off while a frame streams in
    hold_req = 1'b1;
    set_geometry(20, 10);
    while (!hold_active) @(negedge clk_i);
    send_frame(1'b0);
    settle();

    set_geometry(11'h7FF, 2);
    for (int k = 0; k < PARTIAL_ITEMS; k++) offer(CMD_PIXEL, PIX_W'($urandom));
    settle();
    set_geometry(0, 11'h7FF);
    for (int k = 0; k < PARTIAL_ITEMS; k++) offer(CMD_PIXEL, PIX_W'($urandom));
    settle();
    set_geometry(5, 2);
    send_frame(1'b0);
    settle();

    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: set_geometry($urandom_range(0, 2), $urandom_range(0, 2));
        1: set_geometry($urandom_range(13, 24), $urandom_range(9, 12));
        default: set_geometry($urandom_range(3, 12), $urandom_range(3, 8));
      endcase
      repeat ($urandom_range(1, 2)) send_frame(1'b1);
      settle();
    end

    repeat (20) @(negedge clk_i);
    $display("covered %0d frames in %0d geometry settings, %0d input transactions",
             frames_sent, geometries, items_sent);
    $display("checked %0d filtered pixels, %0d mismatches", means_checked, mean_errors);
    if (mean_errors == 0) begin
      $display("box_filter_3x3_zero_pad regression: pass");
    end else begin
      $display("box_filter_3x3_zero_pad regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/boxf_pkg.sv
hw/rtl/boxf_ram.sv
hw/rtl/boxf_cell.sv
hw/rtl/box_filter_3x3_zero_pad.sv
verif/boxf_mean_checker.sv
verif/box_filter_3x3_zero_pad_test.sv
